// ----- hdl/psv_pkg.sv -----
// Package for the positional volume/pan block: register indexes, pipeline
// geometry and arithmetic constants. No dependencies.
`default_nettype none
package psv_pkg;
    localparam int CoordW  = 15;
    localparam int CfgIdxW = 3;

    // register indexes on the config port
    localparam logic [CfgIdxW-1:0] REG_REF_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_REF_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_END_X = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_END_Y = 3'd3;

    // square root: 32-bit radicand, 16-bit root, two bits per stage
    localparam int RadW              = 32;
    localparam int RootW             = 16;
    localparam int SqrtStepsPerStage = 2;
    localparam int SqrtStages        = RootW / SqrtStepsPerStage;

    // pan divider: 8 quotient bits, top bit means saturate
    localparam int DivSteps         = 8;
    localparam int DivStepsPerStage = 2;
    localparam int DivStages        = DivSteps / DivStepsPerStage;
    localparam int NumW             = 34;
    localparam int AbsW             = 33;
    localparam int PanShift         = 4;    // divide by 16

    // three front stages, root, divider, output register
    localparam int PipeDepth = 3 + SqrtStages + DivStages + 1;

    localparam logic [RootW-1:0] NearRadius = 16'd700;
    localparam logic [RootW-1:0] FloorDist  = 16'd3580;   // 700 + 240*12
    localparam logic [16:0]      RecipMul   = 17'd87382;  // ceil(2^20 / 12)
    localparam int               RecipShift = 20;
    localparam logic [7:0]       VolMax     = 8'd255;
    localparam logic [7:0]       VolFloor   = 8'd16;
    localparam logic [6:0]       PanMax     = 7'd127;
endpackage
`default_nettype wire

// ----- hdl/psv_isqrt.sv -----
// Pipelined floor square root, two result bits per stage.
// Uses psv_pkg.
`default_nettype none
module psv_isqrt import psv_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [RadW-1:0]  rad_in,
    output logic      [RootW-1:0] root_out
);
    logic [RadW-1:0]  rem_reg   [SqrtStages];
    logic [RootW-1:0] root_reg  [SqrtStages];
    logic [RadW-1:0]  rem_next  [SqrtStages];
    logic [RootW-1:0] root_next [SqrtStages];

    // rem holds radicand minus root^2; try setting each bit from the top
    always_comb begin : step_logic
        logic [RadW-1:0]  r;
        logic [RootW-1:0] q;
        logic [RadW+1:0]  trial;
        int               bitpos;
        for (int s = 0; s < SqrtStages; s++) begin
            if (s == 0) begin
                r = rad_in;
                q = '0;
            end else begin
                r = rem_reg[s-1];
                q = root_reg[s-1];
            end
            for (int k = 0; k < SqrtStepsPerStage; k++) begin
                bitpos = RootW - 1 - s * SqrtStepsPerStage - k;
                trial  = ((RadW+2)'(q) << (bitpos + 1)) + ((RadW+2)'(1) << (2 * bitpos));
                if ((RadW+2)'(r) >= trial) begin
                    r = r - RadW'(trial);
                    q = q | (RootW'(1) << bitpos);
                end
            end
            rem_next[s]  = r;
            root_next[s] = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SqrtStages; s++) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root_out = root_reg[SqrtStages-1];
endmodule
`default_nettype wire

// ----- hdl/positional_volume_pan.sv -----
// Channel   Dir  Width  Contents
// s_axis    in   32     tdata: pos_x[14:0], pos_y[29:15], zero pad
// m_axis    out  16     tdata: volume[7:0], pan[15:8]
// cfg       in   3+15   cfg_addr register index, cfg_data value
//
// One transfer per cycle when the pipe is not stalled: 3 front stages (differences,
// products, sums), 8 square-root stages, 4 divider stages, output register.
// All stages advance together when the output register is empty or taken;
// a stall freezes the whole pipe, so nothing is dropped or repeated.
// aresetn (synchronous) clears valid bits and the four config registers.
// Depends on psv_pkg and psv_isqrt.
`default_nettype none
module positional_volume_pan import psv_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // pos_x, pos_y from bit 0
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [15:0]        m_tdata,   // volume, pan from bit 0
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_addr,
    input  wire logic [CoordW-1:0]  cfg_data
);
    // ---------------- configuration ----------------
    logic signed [CoordW-1:0] ref_x_reg, ref_y_reg, end_x_reg, end_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            end_x_reg <= '0;
            end_y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_REF_X: ref_x_reg <= cfg_data;
                REG_REF_Y: ref_y_reg <= cfg_data;
                REG_END_X: end_x_reg <= cfg_data;
                REG_END_Y: end_y_reg <= cfg_data;
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [PipeDepth-1:0] vld_reg;
    logic                 en;

    assign en       = !vld_reg[PipeDepth-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PipeDepth-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PipeDepth-2:0], s_tvalid};
        end
    end

    logic signed [CoordW-1:0] pos_x, pos_y;
    assign pos_x = s_tdata[CoordW-1:0];
    assign pos_y = s_tdata[2*CoordW-1:CoordW];

    // ---------------- stage 1: differences, config products ----------------
    logic signed [CoordW:0]     ax1_reg, ay1_reg, ld1_reg, lf1_reg;
    logic signed [CoordW-1:0]   px1_reg, py1_reg;
    logic signed [2*CoordW-1:0] pa1_reg, pb1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= (CoordW+1)'(ref_x_reg) - (CoordW+1)'(pos_x);
            ay1_reg <= (CoordW+1)'(ref_y_reg) - (CoordW+1)'(pos_y);
            ld1_reg <= (CoordW+1)'(end_y_reg) - (CoordW+1)'(ref_y_reg);
            lf1_reg <= (CoordW+1)'(ref_x_reg) - (CoordW+1)'(end_x_reg);
            px1_reg <= pos_x;
            py1_reg <= pos_y;
            pa1_reg <= end_x_reg * ref_y_reg;
            pb1_reg <= ref_x_reg * end_y_reg;
        end
    end

    // ---------------- stage 2: squares and cross terms ----------------
    logic signed [31:0] sqa2_reg, sqb2_reg, sql2_reg, sqf2_reg;
    logic signed [30:0] m1_2_reg, m2_2_reg, lg2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa2_reg <= ax1_reg * ax1_reg;
            sqb2_reg <= ay1_reg * ay1_reg;
            sql2_reg <= ld1_reg * ld1_reg;
            sqf2_reg <= lf1_reg * lf1_reg;
            m1_2_reg <= 31'(px1_reg) * 31'(ld1_reg);
            m2_2_reg <= 31'(py1_reg) * 31'(lf1_reg);
            lg2_reg  <= 31'(pa1_reg) - 31'(pb1_reg);
        end
    end

    // ---------------- stage 3: sums ----------------
    logic [RadW-1:0]        drad3_reg, lrad3_reg;
    logic signed [NumW-1:0] num3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            drad3_reg <= RadW'(sqa2_reg) + RadW'(sqb2_reg);
            lrad3_reg <= RadW'(sql2_reg) + RadW'(sqf2_reg);
            num3_reg  <= NumW'(m1_2_reg) + NumW'(m2_2_reg) + NumW'(lg2_reg);
        end
    end

    // ---------------- stages 4..11: roots ----------------
    logic [RootW-1:0] dist_root, len_root;

    psv_isqrt u_dist_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (drad3_reg),
        .root_out (dist_root)
    );

    psv_isqrt u_len_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (lrad3_reg),
        .root_out (len_root)
    );

    // numerator magnitude and sign ride alongside the roots
    logic [AbsW-1:0] absn_reg [SqrtStages];
    logic            negn_reg [SqrtStages];

    always_ff @(posedge aclk) begin
        if (en) begin
            absn_reg[0] <= num3_reg[NumW-1] ? AbsW'(-num3_reg) : AbsW'(num3_reg);
            negn_reg[0] <= num3_reg[NumW-1];
            for (int s = 1; s < SqrtStages; s++) begin
                absn_reg[s] <= absn_reg[s-1];
                negn_reg[s] <= negn_reg[s-1];
            end
        end
    end

    // ---------------- stages 12..15: pan divide, volume ----------------
    // |num| / (16*len), restoring, bit 7 down to 0; bit 7 set means clamp
    logic [AbsW-1:0]  drem_reg  [DivStages];
    logic [7:0]       dq_reg    [DivStages];
    logic [RootW-1:0] dlen_reg  [DivStages];
    logic             dneg_reg  [DivStages];
    logic [AbsW-1:0]  drem_next [DivStages];
    logic [7:0]       dq_next   [DivStages];

    always_comb begin : div_logic
        logic [AbsW-1:0]  r;
        logic [7:0]       q;
        logic [RootW-1:0] d;
        logic [AbsW:0]    sub;
        int               k;
        for (int s = 0; s < DivStages; s++) begin
            if (s == 0) begin
                r = absn_reg[SqrtStages-1];
                q = '0;
                d = len_root;
            end else begin
                r = drem_reg[s-1];
                q = dq_reg[s-1];
                d = dlen_reg[s-1];
            end
            for (int j = 0; j < DivStepsPerStage; j++) begin
                k   = DivSteps - 1 - s * DivStepsPerStage - j;
                sub = (AbsW+1)'(d) << (PanShift + k);
                if ((AbsW+1)'(r) >= sub) begin
                    r = r - AbsW'(sub);
                    q = q | (8'(1) << k);
                end
            end
            drem_next[s] = r;
            dq_next[s]   = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DivStages; s++) begin
                drem_reg[s] <= drem_next[s];
                dq_reg[s]   <= dq_next[s];
            end
            dlen_reg[0] <= len_root;
            dneg_reg[0] <= negn_reg[SqrtStages-1];
            for (int s = 1; s < DivStages; s++) begin
                dlen_reg[s] <= dlen_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
            end
        end
    end

    // volume: 255 inside the radius, 16 at or past 3580, else 255 - (D-700)/12
    logic             near12_reg, far12_reg, near13_reg, far13_reg;
    logic [11:0]      exc12_reg;
    logic [28:0]      prod13_reg;
    logic [7:0]       vol14_reg, vol15_reg;
    logic [8:0]       quo13;

    assign quo13 = prod13_reg[RecipShift+8:RecipShift];

    always_ff @(posedge aclk) begin
        if (en) begin
            near12_reg <= dist_root <= NearRadius;
            far12_reg  <= dist_root >= FloorDist;
            exc12_reg  <= 12'(dist_root - NearRadius);
            near13_reg <= near12_reg;
            far13_reg  <= far12_reg;
            prod13_reg <= 29'(exc12_reg) * 29'(RecipMul);
            if (near13_reg) begin
                vol14_reg <= VolMax;
            end else if (far13_reg) begin
                vol14_reg <= VolFloor;
            end else begin
                vol14_reg <= VolMax - quo13[7:0];
            end
            vol15_reg <= vol14_reg;
        end
    end

    // ---------------- stage 16: output register ----------------
    logic [7:0] vol_out_reg, pan_out_reg;
    logic [6:0] mag;
    logic [7:0] pan_next;

    always_comb begin
        mag = dq_reg[DivStages-1][7] ? PanMax : dq_reg[DivStages-1][6:0];
        if (dlen_reg[DivStages-1] == '0) begin
            pan_next = '0;   // degenerate line
        end else if (dneg_reg[DivStages-1]) begin
            pan_next = 8'(-{1'b0, mag});
        end else begin
            pan_next = {1'b0, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vol_out_reg <= vol15_reg;
            pan_out_reg <= pan_next;
        end
    end

    assign m_tdata = {pan_out_reg, vol_out_reg};

`ifndef SYNTHESIS
    a_vol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] >= VolFloor)
        else $error("volume below floor");
    a_pan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] != 8'h80)
        else $error("pan out of range");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipe stalled with empty output");
    a_reset_clears: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid after reset");
`endif
endmodule
`default_nettype wire
